/* rtl/bracket_balance_checker_top_macros.svh */
// Assertion helpers for the checker file.
`ifndef BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bracket checker assertion failed");

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bracket checker assertion failed");

`endif

/* rtl/bbc_pkg.sv */
package bbc_pkg;

	// default bracket type stack depth
	localparam int STACK_DEPTH_DEF = 1024;
	// entries in the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// result status codes
	localparam logic [2:0] ST_SCANNING = 3'd0;
	localparam logic [2:0] ST_BALANCED = 3'd1;
	localparam logic [2:0] ST_EXTRA    = 3'd2;
	localparam logic [2:0] ST_MISMATCH = 3'd3;
	localparam logic [2:0] ST_UNCLOSED = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_LBRACK    = 8'h5B;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_RBRACK    = 8'h5D;

	// character classes produced by the front end
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_OPEN_PAREN,
		CLS_OPEN_BRACK,
		CLS_CLOSE_PAREN,
		CLS_CLOSE_BRACK,
		CLS_QUOTE,
		CLS_SEMI,
		CLS_NEWLINE,
		CLS_BACKSLASH
	} cls_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] open_count;
		logic [15:0] error_position;
		logic        done_res;
	} result_t;

	// queue entry: classified byte
	typedef struct packed {
		cls_t cls;
		logic last;
	} item_t;

endpackage

/* rtl/bbc_ram.sv */
module bbc_ram import bbc_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port (read returns old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bbc_front.sv */
module bbc_front import bbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  text_valid,
	output logic  text_stall,
	input  text_t text_data,
	output logic  q_valid,
	input  logic  q_pop,
	output item_t q_item
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	item_t          entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	item_t          cls_item;
	logic           push;

	// classify the incoming byte
	always_comb begin
		cls_item.last = text_data.last_byte;
		unique case (text_data.text_byte)
			CH_LPAREN:    cls_item.cls = CLS_OPEN_PAREN;
			CH_LBRACK:    cls_item.cls = CLS_OPEN_BRACK;
			CH_RPAREN:    cls_item.cls = CLS_CLOSE_PAREN;
			CH_RBRACK:    cls_item.cls = CLS_CLOSE_BRACK;
			CH_QUOTE:     cls_item.cls = CLS_QUOTE;
			CH_SEMI:      cls_item.cls = CLS_SEMI;
			CH_NEWLINE:   cls_item.cls = CLS_NEWLINE;
			CH_BACKSLASH: cls_item.cls = CLS_BACKSLASH;
			default:      cls_item.cls = CLS_OTHER;
		endcase
	end

	assign text_stall = (fill_q == QCW'(QUEUE_DEPTH));
	assign push       = text_valid && !text_stall;
	assign q_valid    = (fill_q != '0);
	assign q_item     = entry_q[rd_ptr_q];

	// queue storage; pointers wrap since depth is a power of two
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + QCW'(1);
				2'b01:   fill_q <= fill_q - QCW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/bbc_back.sv */
module bbc_back import bbc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_pop,
	input  item_t   q_item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// scanner state
	logic [CW-1:0] count_q, cnt_n;
	logic          top_q, top_n;
	logic [15:0]   bal_q, bal_n;
	logic          str_q, str_n;
	logic          cmt_q, cmt_n;
	logic          pbs_q, pbs_n;
	logic [15:0]   idx_q, idx_n;
	logic [2:0]    held_q, held_n;
	logic [15:0]   hpos_q, hpos_n;

	// stack memory holds everything below the cached top entry
	logic          byp_valid_q;
	logic          byp_data_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;
	logic          below;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_n_m2;

	logic          out_valid_q;
	result_t       out_q;
	result_t       res;
	logic          out_ok;
	logic          fire;
	logic          is_sq;

	bbc_ram #(
		.WIDTH(1),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_ok = !out_valid_q || !result_stall;
	assign fire   = q_valid && out_ok;
	assign q_pop  = fire;
	assign below  = byp_valid_q ? byp_data_q : ram_rdata;
	assign cnt_m1 = count_q - CW'(1);
	assign is_sq  = (q_item.cls == CLS_OPEN_BRACK) || (q_item.cls == CLS_CLOSE_BRACK);

	// per-byte scan step
	always_comb begin
		cnt_n     = count_q;
		top_n     = top_q;
		bal_n     = bal_q;
		str_n     = str_q;
		cmt_n     = cmt_q;
		pbs_n     = pbs_q;
		idx_n     = idx_q;
		held_n    = held_q;
		hpos_n    = hpos_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_m1[AW-1:0];
		ram_wdata = top_q;
		res       = out_q;
		if (fire) begin
			if (held_q == ST_SCANNING) begin
				// comment tracking
				if (q_item.cls == CLS_SEMI && !str_q) begin
					cmt_n = 1'b1;
				end else if (q_item.cls == CLS_NEWLINE && cmt_q) begin
					cmt_n = 1'b0;
				end
				if (!cmt_n) begin
					// string tracking, escaped quote does not toggle
					if (q_item.cls == CLS_QUOTE && !pbs_q) begin
						str_n = !str_q;
					end
					if (!str_n) begin
						case (q_item.cls) inside
							CLS_OPEN_PAREN, CLS_OPEN_BRACK: begin
								if (bal_q != 16'hFFFF) begin
									bal_n = bal_q + 16'd1;
								end
								// full stack drops the push
								if (count_q < CW'(STACK_DEPTH)) begin
									ram_we = (count_q != '0);
									top_n  = is_sq;
									cnt_n  = count_q + CW'(1);
								end
							end
							CLS_CLOSE_PAREN, CLS_CLOSE_BRACK: begin
								if (bal_q == '0) begin
									held_n = ST_EXTRA;
									hpos_n = idx_q;
								end else begin
									bal_n = bal_q - 16'd1;
									// opener lost to a full stack: no type check
									if (count_q != '0) begin
										cnt_n = cnt_m1;
										top_n = below;
										if (top_q != is_sq) begin
											held_n = ST_MISMATCH;
											hpos_n = idx_q;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			pbs_n = (q_item.cls == CLS_BACKSLASH);

			// result for this byte
			res.status         = held_n;
			res.open_count     = bal_n;
			res.error_position = hpos_n;
			res.done_res       = q_item.last;
			if (q_item.last && held_n == ST_SCANNING) begin
				if (bal_n != '0) begin
					res.status         = ST_UNCLOSED;
					res.error_position = idx_q;
				end else begin
					res.status         = ST_BALANCED;
					res.error_position = '0;
				end
			end

			// end of text returns to the reset state
			if (q_item.last) begin
				cnt_n  = '0;
				bal_n  = '0;
				str_n  = 1'b0;
				cmt_n  = 1'b0;
				pbs_n  = 1'b0;
				idx_n  = '0;
				held_n = ST_SCANNING;
				hpos_n = '0;
			end else if (idx_q != 16'hFFFF) begin
				idx_n = idx_q + 16'd1;
			end
		end
	end

	// prefetch the entry below the next top
	assign cnt_n_m2  = cnt_n - CW'(2);
	assign ram_raddr = cnt_n_m2[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bal_q       <= '0;
			str_q       <= 1'b0;
			cmt_q       <= 1'b0;
			pbs_q       <= 1'b0;
			idx_q       <= '0;
			held_q      <= ST_SCANNING;
			hpos_q      <= '0;
			byp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= cnt_n;
			bal_q       <= bal_n;
			str_q       <= str_n;
			cmt_q       <= cmt_n;
			pbs_q       <= pbs_n;
			idx_q       <= idx_n;
			held_q      <= held_n;
			hpos_q      <= hpos_n;
			// write and prefetch to the same entry: forward the new data
			byp_valid_q <= ram_we && (ram_waddr == ram_raddr);
			if (out_ok) begin
				out_valid_q <= fire;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		top_q      <= top_n;
		byp_data_q <= ram_wdata;
		if (fire) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

/* rtl/bracket_balance_checker_top.sv */
// Path: an accepted byte is classified and written into the queue, then scanned by the back end
// and held in its output register; bytes waiting ahead in the queue or a stalled result delay it.
// Throughput: one byte per cycle unless stalled, set by the back end's stack-top update, which keeps
// the top entry in a register and prefetches the one below from the one-read one-write stack memory.
// Reset: arst_n asynchronously clears flags, counters, queue and output valid; the stack
// memory is not cleared and needs no clearing pass, bytes are taken right after reset.
module bracket_balance_checker_top import bbc_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    text_valid,
	output logic    text_stall,
	input  text_t   text_data,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	bbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_data  (text_data),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	bbc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

/* rtl/bbc_checker.sv */
`include "bracket_balance_checker_top_macros.svh"

module bbc_checker import bbc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result_data
);

	// a stalled result holds
	`BBC_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_data))

	// end-of-text codes only come with the done mark
	`BBC_ASSERT_NOW(a_end_done, clk, arst_n, result_valid && (result_data.status == ST_BALANCED || result_data.status == ST_UNCLOSED), result_data.done_res)

	// balanced end means nothing open
	`BBC_ASSERT_NOW(a_bal_zero, clk, arst_n, result_valid && result_data.status == ST_BALANCED, result_data.open_count == '0 && result_data.error_position == '0)

	// unclosed end means something open
	`BBC_ASSERT_NOW(a_uncl_open, clk, arst_n, result_valid && result_data.status == ST_UNCLOSED, result_data.open_count != '0)

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);

/* verif/bracket_balance_checker_top_test.sv */
import bbc_pkg::*;

// Follows the checker state transfer by transfer and keeps the results it predicts.
class balance_tracker;
	bit          stack_kind[STACK_DEPTH_DEF]; // 1 for '[', 0 for '('
	int unsigned stack_used;
	logic [15:0] open_bal;
	logic [15:0] byte_pos;
	logic [15:0] held_pos;
	logic [2:0]  held_st;
	bit          in_str;
	bit          in_cmt;
	bit          after_bs;
	result_t     pending_results[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
		clear_text();
	endfunction

	// back to the start-of-text state; stack entries are never read before written
	function void clear_text();
		stack_used = 0;
		open_bal = '0;
		byte_pos = '0;
		held_pos = '0;
		held_st = ST_SCANNING;
		in_str = 1'b0;
		in_cmt = 1'b0;
		after_bs = 1'b0;
	endfunction

	// comment / string tracking and bracket stack update for one byte
	function void scan_char(logic [7:0] ch);
		if (ch == CH_SEMI && !in_str)
			in_cmt = 1'b1;
		else if (ch == CH_NEWLINE && in_cmt)
			in_cmt = 1'b0;
		if (in_cmt)
			return;
		if (ch == CH_QUOTE && !after_bs)
			in_str = !in_str;
		if (in_str)
			return;
		if (ch == CH_LPAREN || ch == CH_LBRACK) begin
			if (open_bal != 16'hFFFF)
				open_bal++;
			// push is dropped when full, the opener still counts
			if (stack_used < STACK_DEPTH_DEF) begin
				stack_kind[stack_used] = (ch == CH_LBRACK);
				stack_used++;
			end
		end else if (ch == CH_RPAREN || ch == CH_RBRACK) begin
			if (open_bal == 0) begin
				held_st = ST_EXTRA;
				held_pos = byte_pos;
				return;
			end
			open_bal--;
			// empty stack with open brackets left: decrement only, no type check
			if (stack_used > 0) begin
				stack_used--;
				if (stack_kind[stack_used] != (ch == CH_RBRACK)) begin
					held_st = ST_MISMATCH;
					held_pos = byte_pos;
				end
			end
		end
	endfunction

	// accepted input transfer: predict its result
	function void take_byte(text_t t);
		result_t r;
		if (held_st == ST_SCANNING)
			scan_char(t.text_byte);
		after_bs = (t.text_byte == CH_BACKSLASH);
		r.status = held_st;
		r.open_count = open_bal;
		r.error_position = held_pos;
		r.done_res = t.last_byte;
		if (t.last_byte && held_st == ST_SCANNING) begin
			if (open_bal != 0) begin
				r.status = ST_UNCLOSED;
				r.error_position = byte_pos;
			end else begin
				r.status = ST_BALANCED;
				r.error_position = '0;
			end
		end
		pending_results.push_back(r);
		if (t.last_byte)
			clear_text();
		else if (byte_pos != 16'hFFFF)
			byte_pos++;
	endfunction

	task report(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
	endtask

	// accepted result transfer: compare with the oldest prediction
	task check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report("unexpected result", 32'(got.status), 0);
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status)
			report("status", 32'(got.status), 32'(want.status));
		if (got.open_count !== want.open_count)
			report("open_count", 32'(got.open_count), 32'(want.open_count));
		if (got.error_position !== want.error_position)
			report("error_position", 32'(got.error_position), 32'(want.error_position));
		if (got.done_res !== want.done_res)
			report("done_res", 32'(got.done_res), 32'(want.done_res));
	endtask

	function int pending();
		return pending_results.size();
	endfunction
endclass

module bracket_balance_checker_top_test;

	localparam int STALL_LIMIT  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 170;

	typedef enum int {TXT_CLEAN, TXT_BROKEN, TXT_NOISE} text_kind_t;

	logic    clk;
	logic    arst_n;
	logic    text_valid;
	logic    text_stall;
	text_t   text_data;
	logic    result_valid;
	logic    result_stall;
	result_t result_data;

	balance_tracker tracker;
	logic [7:0]     text_buf[$];
	int             tx_idle_max;
	int             rx_idle_max;
	int             quiet_cycles;

	bracket_balance_checker_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_data   (text_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// monitor both channels and watch for a hang
	always @(posedge clk) begin : monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (text_valid && !text_stall) begin
				tracker.take_byte(text_data);
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				tracker.check_result(result_data);
				moved = 1'b1;
			end
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAIL bracket_balance_checker_top");
				$finish;
			end
		end
	end

	// one input transfer, entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		text_t t;
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		t.text_byte = b;
		t.last_byte = is_last;
		text_valid <= 1'b1;
		text_data <= t;
		do @(posedge clk); while (text_stall);
		@(negedge clk);
	endtask

	task automatic send_text();
		int i;
		tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
		rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
		for (i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	task automatic add_chars(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic add_run(input logic [7:0] ch, input int n);
		repeat (n) text_buf.push_back(ch);
	endtask

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 8))
			0: return CH_SEMI;
			1: return CH_NEWLINE;
			2: return CH_QUOTE;
			3: return CH_BACKSLASH;
			4: return CH_LPAREN;
			5: return CH_LBRACK;
			6: return CH_RPAREN;
			7: return CH_RBRACK;
			default: return 8'h20;
		endcase
	endfunction

	function automatic logic [7:0] filler_char();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// quoted string with brackets, semicolons and escaped quotes inside
	task automatic add_string();
		int m;
		text_buf.push_back(CH_QUOTE);
		m = $urandom_range(0, 6);
		repeat (m) begin
			if ($urandom_range(0, 4) == 0) begin
				text_buf.push_back(CH_BACKSLASH);
				text_buf.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'h6E);
			end else if ($urandom_range(0, 1)) begin
				text_buf.push_back(special_char());
			end else begin
				text_buf.push_back(filler_char());
			end
		end
		text_buf.push_back(CH_QUOTE);
	endtask

	// line comment with random content, closed by a newline
	task automatic add_comment();
		int m;
		logic [7:0] ch;
		text_buf.push_back(CH_SEMI);
		m = $urandom_range(0, 6);
		repeat (m) begin
			ch = $urandom_range(0, 1) ? special_char() : filler_char();
			if (ch != CH_NEWLINE)
				text_buf.push_back(ch);
		end
		text_buf.push_back(CH_NEWLINE);
	endtask

	// mostly nested bracket texts with strings and comments; broken ones get one flaw
	task automatic build_random_text(input text_kind_t kind);
		bit opened[$];
		int n;
		int c;
		int flaw;
		bit k;
		bit first_close;
		n = $urandom_range(1, 24);
		flaw = $urandom_range(0, 2);
		if (kind == TXT_NOISE) begin
			repeat (n)
				text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: special_char());
			return;
		end
		repeat (n) begin
			c = $urandom_range(0, 99);
			if (c < 30) begin
				k = 1'($urandom_range(0, 1));
				opened.push_back(k);
				text_buf.push_back(k ? CH_LBRACK : CH_LPAREN);
			end else if (c < 55 && opened.size() > 0) begin
				k = opened.pop_back();
				text_buf.push_back(k ? CH_RBRACK : CH_RPAREN);
			end else if (c < 65) begin
				add_string();
			end else if (c < 72) begin
				add_comment();
			end else if (c < 75) begin
				text_buf.push_back(CH_BACKSLASH);
			end else begin
				text_buf.push_back(filler_char());
			end
		end
		if (kind == TXT_BROKEN && flaw == 0 && opened.size() == 0) begin
			opened.push_back(1'b0);
			text_buf.push_back(CH_LPAREN);
		end
		if (!(kind == TXT_BROKEN && flaw == 2)) begin
			first_close = 1'b1;
			while (opened.size() > 0) begin
				k = opened.pop_back();
				if (kind == TXT_BROKEN && flaw == 0 && first_close)
					k = !k;
				first_close = 1'b0;
				text_buf.push_back(k ? CH_RBRACK : CH_RPAREN);
			end
		end
		if (kind == TXT_BROKEN && flaw == 1)
			text_buf.push_back($urandom_range(0, 1) ? CH_RBRACK : CH_RPAREN);
		if (kind == TXT_BROKEN && flaw == 2)
			text_buf.push_back(CH_LBRACK);
	endtask

	// result side: random stall before each result transfer
	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = $urandom_range(0, rx_idle_max);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int random_bytes;
		int c;
		text_kind_t kind;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_data = '0;
		result_stall = 1'b0;
		tx_idle_max = 6;
		rx_idle_max = 6;
		quiet_cycles = 0;
		tracker = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed texts
		add_chars("x");                 send_text(); // single byte, balanced
		add_chars(")");                 send_text(); // extra closer at index zero
		add_chars("\"(");               send_text(); // quote on first byte toggles
		add_chars("(]((((");            send_text(); // mismatch, rest ignored
		add_chars("[)");                send_text();
		add_chars("(([");               send_text(); // unclosed at end
		add_chars("; ( [\n()");         send_text(); // comment hides brackets
		add_chars("\"a\\\"(\")");       send_text(); // escaped quote inside string
		add_chars("\";(\"()");          send_text(); // semicolon inside string
		add_chars("a\\\"(");            send_text(); // escaped quote outside string
		text_buf.push_back(8'h00);
		text_buf.push_back(CH_LPAREN);
		text_buf.push_back(8'hFF);
		text_buf.push_back(CH_RPAREN);
		send_text();
		add_chars("([])[()]");          send_text();
		add_chars("\n)\n");             send_text(); // newline outside a comment
		// dropped push seen as a type mismatch
		add_run(CH_LPAREN, STACK_DEPTH_DEF);
		add_chars("[]");
		send_text();

		// random texts
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			c = $urandom_range(0, 19);
			kind = (c < 15) ? TXT_CLEAN : (c < 18) ? TXT_BROKEN : TXT_NOISE;
			build_random_text(kind);
			random_bytes += text_buf.size();
			send_text();
		end
		text_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("PASS bracket_balance_checker_top");
		else
			$display("FAIL bracket_balance_checker_top");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_front.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker_top.sv
rtl/bbc_checker.sv
verif/bracket_balance_checker_top_test.sv
